// ===== sv/software_timer_bank_unit_defines.svh =====
// ---------------------------------------------------------------------------
// software_timer_bank_unit_defines
// Assertion macros used by the timer bank datapath.
// ---------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_UNIT_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STB_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define STB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/stb_pkg.sv =====
// ---------------------------------------------------------------------------
// stb_pkg
// Types, widths and codes shared by the timer bank controller and datapath.
// ---------------------------------------------------------------------------
package stb_pkg;

   localparam int NUM_TIMERS_DEFAULT = 8;
   localparam int ACTION_W           = 2;
   localparam int TIMER_IDX_W        = 3;
   localparam int COUNT_W            = 16;

   localparam logic [COUNT_W-1:0] TICK_STEP_RESET = 16'd10;

   localparam logic [ACTION_W-1:0] ACT_SET      = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SET,
      ST_TICK,
      ST_DISPATCH
   } stb_state_type;

   typedef struct packed {
      logic capture;       // latch request fields, rewind sweep index
      logic set_write;     // load the addressed timer
      logic tick_advance;  // tick one timer, advance index
      logic disp_advance;  // examine one pending flag, advance index
   } stb_cmd_type;

   typedef struct packed {
      logic sweep_last;    // index is on the final timer
      logic disp_done;     // this dispatch cycle reports the last result
   } stb_status_type;

endpackage

// ===== sv/stb_controller.sv =====
// ---------------------------------------------------------------------------
// stb_controller
// Request sequencer: decodes the action and steps the datapath sweep.
// ---------------------------------------------------------------------------
module stb_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [stb_pkg::ACTION_W-1:0]         req_action,
   input  stb_pkg::stb_status_type              status,
   output stb_pkg::stb_cmd_type                 cmd
);
   import stb_pkg::*;

   stb_state_type state_ff;
   stb_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_action)
                  ACT_SET:      state_in = ST_SET;
                  ACT_TICK:     state_in = ST_TICK;
                  ACT_DISPATCH: state_in = ST_DISPATCH;
                  default:      state_in = ST_IDLE;  // drop unused code
               endcase
            end
         end
         ST_SET: begin
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DISPATCH: begin
            if (status.disp_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b1;
      cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_SET: begin
            cmd.set_write = 1'b1;
         end
         ST_TICK: begin
            cmd.tick_advance = 1'b1;
         end
         ST_DISPATCH: begin
            cmd.disp_advance = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== sv/stb_datapath.sv =====
// ---------------------------------------------------------------------------
// stb_datapath
// Timer state, tick step register, one-timer-per-cycle sweep and result
// registers.
// ---------------------------------------------------------------------------
`include "software_timer_bank_unit_defines.svh"

module stb_datapath #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stb_pkg::stb_cmd_type                 cmd,
   output stb_pkg::stb_status_type              status,
   input  logic [stb_pkg::TIMER_IDX_W-1:0]      req_timer_index,
   input  logic [stb_pkg::COUNT_W-1:0]          req_delay,
   input  logic                                 req_rearm,
   input  logic                                 req_has_handler,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [stb_pkg::COUNT_W-1:0]          csr_wdata,
   output logic                                 rsp_valid,
   output logic [stb_pkg::TIMER_IDX_W-1:0]      rsp_fired_index,
   output logic                                 rsp_fired_valid,
   output logic                                 rsp_last
);
   import stb_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   logic [COUNT_W-1:0]     tick_step_ff;
   logic [COUNT_W-1:0]     count_ff  [NUM_TIMERS];
   logic [COUNT_W-1:0]     count_in  [NUM_TIMERS];
   logic [COUNT_W-1:0]     reload_ff [NUM_TIMERS];
   logic [COUNT_W-1:0]     reload_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  handler_ff;
   logic [NUM_TIMERS-1:0]  handler_in;
   logic [NUM_TIMERS-1:0]  pending_ff;
   logic [NUM_TIMERS-1:0]  pending_in;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       idx_in;

   logic [TIMER_IDX_W-1:0] item_idx_ff;
   logic [COUNT_W-1:0]     item_delay_ff;
   logic                   item_rearm_ff;
   logic                   item_handler_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [TIMER_IDX_W-1:0] rsp_index_ff;
   logic [TIMER_IDX_W-1:0] rsp_index_in;
   logic                   rsp_fvalid_ff;
   logic                   rsp_fvalid_in;
   logic                   rsp_last_ff;
   logic                   rsp_last_in;

   logic [COUNT_W-1:0]     cur_count;
   logic [COUNT_W-1:0]     diff;
   logic                   pend_cur;
   logic [NUM_TIMERS-1:0]  idx_onehot;
   logic                   others_pending;

   assign cur_count      = count_ff[idx_ff];
   assign diff           = cur_count - tick_step_ff;
   assign pend_cur       = pending_ff[idx_ff];
   assign idx_onehot     = NUM_TIMERS'(1) << idx_ff;
   assign others_pending = |(pending_ff & ~idx_onehot);

   assign status.sweep_last = (32'(idx_ff) == NUM_TIMERS - 1);
   assign status.disp_done  = (pending_ff == '0) || (pend_cur && !others_pending);

   always_comb begin
      count_in      = count_ff;
      reload_in     = reload_ff;
      handler_in    = handler_ff;
      pending_in    = pending_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_fvalid_in = rsp_fvalid_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.capture) begin
         idx_in = '0;
      end

      if (cmd.set_write) begin
         // out-of-range index matches no timer, so the request is dropped
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (32'(item_idx_ff) == i) begin
               count_in[i]   = item_delay_ff;
               reload_in[i]  = item_rearm_ff ? item_delay_ff : '0;
               handler_in[i] = item_handler_ff;
               pending_in[i] = 1'b0;
            end
         end
      end

      if (cmd.tick_advance) begin
         if (cur_count != '0) begin
            // only an exact landing on zero expires; overshoot wraps
            if (diff == '0 && handler_ff[idx_ff]) begin
               pending_in[idx_ff] = 1'b1;
               count_in[idx_ff]   = reload_ff[idx_ff];
            end else begin
               count_in[idx_ff] = diff;
            end
         end
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.disp_advance) begin
         if (pending_ff == '0) begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = '0;
            rsp_fvalid_in = 1'b0;
            rsp_last_in   = 1'b1;
         end else if (pend_cur) begin
            pending_in[idx_ff] = 1'b0;
            rsp_valid_in       = 1'b1;
            rsp_index_in       = TIMER_IDX_W'(32'(idx_ff));
            rsp_fvalid_in      = 1'b1;
            rsp_last_in        = !others_pending;
         end
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff <= TICK_STEP_RESET;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            count_ff[i]  <= '0;
            reload_ff[i] <= '0;
         end
         handler_ff   <= '0;
         pending_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tick_step_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         reload_ff    <= reload_in;
         handler_ff   <= handler_in;
         pending_ff   <= pending_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_idx_ff     <= req_timer_index;
         item_delay_ff   <= req_delay;
         item_rearm_ff   <= req_rearm;
         item_handler_ff <= req_has_handler;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_fvalid_ff <= rsp_fvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired_index = rsp_index_ff;
   assign rsp_fired_valid = rsp_fvalid_ff;
   assign rsp_last        = rsp_last_ff;

   `STB_ASSERT_NOW(a_none_is_last, rsp_valid_ff && !rsp_fvalid_ff, rsp_last_ff,
      "empty dispatch result not marked last")
   `STB_ASSERT_NOW(a_last_drains, rsp_valid_ff && rsp_fvalid_ff && rsp_last_ff,
      pending_ff == '0, "pending flags remain after last dispatch result")
   `STB_ASSERT_NEXT(a_report_clears, cmd.disp_advance && pend_cur,
      !pending_ff[$past(idx_ff)], "reported timer still pending")

endmodule

// ===== sv/software_timer_bank_unit.sv =====
// ---------------------------------------------------------------------------
// software_timer_bank_unit
// Bank of NUM_TIMERS countdown timers with auto-reload and pending dispatch.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A set request loads
// the addressed timer; a tick request sweeps all NUM_TIMERS timers, one timer
// per cycle through a single subtract and compare; a dispatch request walks
// the pending flags from timer 0 up to the highest pending one, examining at
// most NUM_TIMERS timers. Dispatch results leave on rsp_valid, one per
// examined pending timer or one empty result marked last when none are
// pending, each registered in the cycle after its timer is examined, and not
// necessarily in consecutive cycles. There is no backpressure: the receiver
// must take every result in the cycle rsp_valid is high. Only timers 0 to 7
// are reachable by a set request. The tick step register may be written
// only while busy is low and no result is outstanding.
// ---------------------------------------------------------------------------
module software_timer_bank_unit #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [stb_pkg::ACTION_W-1:0]         req_action,
   input  logic [stb_pkg::TIMER_IDX_W-1:0]      req_timer_index,
   input  logic [stb_pkg::COUNT_W-1:0]          req_delay,
   input  logic                                 req_rearm,
   input  logic                                 req_has_handler,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [stb_pkg::COUNT_W-1:0]          csr_wdata,
   output logic                                 rsp_valid,
   output logic [stb_pkg::TIMER_IDX_W-1:0]      rsp_fired_index,
   output logic                                 rsp_fired_valid,
   output logic                                 rsp_last
);
   import stb_pkg::*;

   stb_cmd_type    cmd;
   stb_status_type status;

   // register is always writable
   assign csr_ready = 1'b1;

   stb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   stb_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_timer_index (req_timer_index),
      .req_delay       (req_delay),
      .req_rearm       (req_rearm),
      .req_has_handler (req_has_handler),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_fired_index (rsp_fired_index),
      .rsp_fired_valid (rsp_fired_valid),
      .rsp_last        (rsp_last)
   );

endmodule
